FILE: rtl/rvx_pkg.sv
// rvx_pkg: opcodes, fixed encodings and shared types for the RV32I execute block.
// No dependencies.
package rvx_pkg;

    localparam int unsigned MEM_BYTES_DEF = 65536;

    localparam logic [31:0] HALT_WORD = 32'h0FF0_0513;

    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_REG    = 7'h33;

    localparam logic [6:0] F7_ZERO = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // register file write port
    typedef struct packed {
        logic        we;
        logic [4:0]  idx;
        logic [31:0] val;
    } t_rf_wr;

endpackage

FILE: rtl/rvx_if.sv
// rvx_in_if / rvx_out_if: valid/ready channels for items and results.
// Depends on nothing.
interface rvx_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] load_address;
    logic [7:0]  load_byte;
    logic [31:0] instruction;
    modport source (output valid, mode, load_address, load_byte, instruction, input ready);
    modport sink (input valid, mode, load_address, load_byte, instruction, output ready);
endinterface

interface rvx_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_pc;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic        dest_write;
    logic        halted;
    logic        illegal;
    modport source (output valid, next_pc, dest_index, dest_value, dest_write, halted, illegal,
                    input ready);
    modport sink (input valid, next_pc, dest_index, dest_value, dest_write, halted, illegal,
                  output ready);
endinterface

FILE: rtl/rvx_regfile.sv
// rvx_regfile: 32x32 register memory, two registered read ports, per-entry valid bits
// and a bypass of the most recent write. Depends on rvx_pkg.
module rvx_regfile (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_en,
    input  logic [4:0]      i_ra1,
    input  logic [4:0]      i_ra2,
    input  rvx_pkg::t_rf_wr i_wr,
    output logic [31:0]     o_rd1,
    output logic [31:0]     o_rd2
);
    logic [31:0] mem [32];
    logic [31:0] r_valid;
    logic [31:0] r_q1, r_q2;
    logic        r_v1, r_v2;
    logic [4:0]  r_ra1, r_ra2;
    logic        r_fwd_v;
    logic [4:0]  r_fwd_idx;
    logic [31:0] r_fwd_val;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.idx] <= i_wr.val;
        end
        if (i_rd_en) begin
            r_q1  <= mem[i_ra1];
            r_q2  <= mem[i_ra2];
            r_ra1 <= i_ra1;
            r_ra2 <= i_ra2;
        end
        if (i_wr.we) begin
            r_fwd_idx <= i_wr.idx;
            r_fwd_val <= i_wr.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_fwd_v <= 1'b0;
        end else begin
            if (i_wr.we) begin
                r_valid[i_wr.idx] <= 1'b1;
                r_fwd_v           <= 1'b1;
            end
            if (i_rd_en) begin
                r_v1 <= r_valid[i_ra1];
                r_v2 <= r_valid[i_ra2];
            end
        end
    end

    // a write landing on the same edge as the read is caught by the bypass
    assign o_rd1 = (r_fwd_v && r_fwd_idx == r_ra1) ? r_fwd_val : (r_v1 ? r_q1 : 32'd0);
    assign o_rd2 = (r_fwd_v && r_fwd_idx == r_ra2) ? r_fwd_val : (r_v2 ? r_q2 : 32'd0);
endmodule

FILE: rtl/rvx_dmem.sv
// rvx_dmem: byte data memory as four byte-lane banks, one write and one registered
// read per bank per cycle. Depends on rvx_pkg for the default size.
module rvx_dmem #(
    parameter int unsigned MEM_BYTES = rvx_pkg::MEM_BYTES_DEF,
    localparam int unsigned RW = $clog2(MEM_BYTES) - 2
) (
    input  logic                 i_clk,
    input  logic [3:0]           i_we,
    input  logic [3:0][RW-1:0]   i_wrow,
    input  logic [3:0][7:0]      i_wdat,
    input  logic                 i_re,
    input  logic [3:0][RW-1:0]   i_rrow,
    output logic [3:0][7:0]      o_rdat
);
    localparam int unsigned ROWS = MEM_BYTES / 4;

    for (genvar k = 0; k < 4; k++) begin : g_bank
        logic [7:0] mem [ROWS];
        logic [7:0] r_q;
        always_ff @(posedge i_clk) begin
            if (i_we[k]) begin
                mem[i_wrow[k]] <= i_wdat[k];
            end
            if (i_re) begin
                r_q <= mem[i_rrow[k]];
            end
        end
        assign o_rdat[k] = r_q;
    end
endmodule

FILE: rtl/rv32i_instruction_execute.sv
// rv32i_instruction_execute: RV32I execute step around a register memory and a byte memory.
// Depends on rvx_pkg, rvx_if, rvx_regfile, rvx_dmem.
//
//  channel  dir  transfer             payload
//  i_in     in   valid & ready        mode, load_address, load_byte, instruction
//  o_res    out  valid & ready        next_pc, dest_index, dest_value, dest_write, halted, illegal
//
// Item accepted at an edge is executed in the next cycle with register operands read then.
// Non-load items finish in that cycle, so one item per cycle unless the output stalls; loads first
// spend a wait phase on the data memory read. Results sit in an output register; a stalled output
// holds the item. Reset clears pc and register valid bits; MEM_BYTES must be a power of two.
module rv32i_instruction_execute #(
    parameter int unsigned MEM_BYTES = rvx_pkg::MEM_BYTES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rvx_in_if.sink    i_in,
    rvx_out_if.source o_res
);
    localparam int unsigned AW = $clog2(MEM_BYTES);
    localparam int unsigned RW = AW - 2;

    logic        r_busy, r_phase, r_mode;
    logic [15:0] r_la;
    logic [7:0]  r_lb;
    logic [31:0] r_ins, r_pc;
    logic        r_out_v;
    logic [31:0] r_o_npc, r_o_val;
    logic [4:0]  r_o_idx;
    logic        r_o_wr, r_o_halt, r_o_bad;

    logic accept, slot_free, finish, ld_go, halt;
    logic [31:0] a, b, npc, val, addr, imm_i, imm_s, imm_b, imm_u, imm_j;
    logic wr, bad, take;
    logic [6:0] op, f7;
    logic [2:0] f3;
    logic [4:0] rd;
    logic [3:0][7:0] q;
    logic [3:0][7:0] ld_b;
    logic [3:0] we;
    logic [3:0][RW-1:0] wrow, rrow;
    logic [3:0][7:0] wdat;
    logic [AW-1:0] maddr, laddr;
    rvx_pkg::t_rf_wr rf_wr;

    assign accept = i_in.valid && i_in.ready;
    assign slot_free = !r_out_v || o_res.ready;

    rvx_regfile u_rf (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_rd_en(accept),
        .i_ra1(i_in.instruction[19:15]), .i_ra2(i_in.instruction[24:20]),
        .i_wr(rf_wr), .o_rd1(a), .o_rd2(b)
    );

    assign op = r_ins[6:0];
    assign rd = r_ins[11:7];
    assign f3 = r_ins[14:12];
    assign f7 = r_ins[31:25];
    assign halt = r_ins == rvx_pkg::HALT_WORD;
    assign imm_i = {{20{r_ins[31]}}, r_ins[31:20]};
    assign imm_s = {{20{r_ins[31]}}, r_ins[31:25], r_ins[11:7]};
    assign imm_b = {{19{r_ins[31]}}, r_ins[31], r_ins[7], r_ins[30:25], r_ins[11:8], 1'b0};
    assign imm_u = {r_ins[31:12], 12'd0};
    assign imm_j = {{11{r_ins[31]}}, r_ins[31], r_ins[19:12], r_ins[20], r_ins[30:21], 1'b0};
    assign addr = a + ((op == rvx_pkg::OP_STORE) ? imm_s : imm_i);
    assign maddr = addr[AW-1:0];
    assign laddr = AW'({16'd0, r_la});

    // bytes of the load in address order, picked from the banks
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            ld_b[i] = q[2'(maddr[1:0] + 2'(i))];
        end
    end

    always_comb begin
        logic t;
        t   = 1'b0;
        npc = r_pc + 32'd4;
        val = 32'd0;
        wr  = 1'b0;
        bad = 1'b0;
        case (op)
            rvx_pkg::OP_LUI: begin
                val = imm_u; wr = 1'b1;
            end
            rvx_pkg::OP_AUIPC: begin
                val = r_pc + imm_u; wr = 1'b1;
            end
            rvx_pkg::OP_JAL: begin
                val = r_pc + 32'd4; npc = r_pc + imm_j; wr = 1'b1;
            end
            rvx_pkg::OP_JALR: begin
                if (f3 != 3'd0) begin
                    bad = 1'b1;
                end else begin
                    val = r_pc + 32'd4; npc = (a + imm_i) & ~32'd1; wr = 1'b1;
                end
            end
            rvx_pkg::OP_BRANCH: begin
                case (f3)
                    3'd0: t = a == b;
                    3'd1: t = a != b;
                    3'd4: t = $signed(a) < $signed(b);
                    3'd5: t = !($signed(a) < $signed(b));
                    3'd6: t = a < b;
                    3'd7: t = a >= b;
                    default: bad = 1'b1;
                endcase
                if (t) begin
                    npc = r_pc + imm_b;
                end
            end
            rvx_pkg::OP_LOAD: begin
                case (f3)
                    3'd0: val = {{24{ld_b[0][7]}}, ld_b[0]};
                    3'd1: val = {{16{ld_b[1][7]}}, ld_b[1], ld_b[0]};
                    3'd2: val = {ld_b[3], ld_b[2], ld_b[1], ld_b[0]};
                    3'd4: val = {24'd0, ld_b[0]};
                    3'd5: val = {16'd0, ld_b[1], ld_b[0]};
                    default: bad = 1'b1;
                endcase
                wr = !bad;
            end
            rvx_pkg::OP_STORE: begin
                bad = f3 > 3'd2;
            end
            rvx_pkg::OP_IMM: begin
                case (f3)
                    3'd0: val = a + imm_i;
                    3'd2: val = {31'd0, $signed(a) < $signed(imm_i)};
                    3'd3: val = {31'd0, a < imm_i};
                    3'd4: val = a ^ imm_i;
                    3'd6: val = a | imm_i;
                    3'd7: val = a & imm_i;
                    3'd1: begin
                        if (f7 == rvx_pkg::F7_ZERO) val = a << r_ins[24:20];
                        else bad = 1'b1;
                    end
                    default: begin
                        if (f7 == rvx_pkg::F7_ZERO) val = a >> r_ins[24:20];
                        else if (f7 == rvx_pkg::F7_ALT) val = 32'($signed(a) >>> r_ins[24:20]);
                        else bad = 1'b1;
                    end
                endcase
                wr = !bad;
            end
            rvx_pkg::OP_REG: begin
                if (f7 == rvx_pkg::F7_ALT && f3 == 3'd0) val = a - b;
                else if (f7 == rvx_pkg::F7_ALT && f3 == 3'd5) val = 32'($signed(a) >>> b[4:0]);
                else if (f7 != rvx_pkg::F7_ZERO) bad = 1'b1;
                else begin
                    case (f3)
                        3'd0: val = a + b;
                        3'd1: val = a << b[4:0];
                        3'd2: val = {31'd0, $signed(a) < $signed(b)};
                        3'd3: val = {31'd0, a < b};
                        3'd4: val = a ^ b;
                        3'd5: val = a >> b[4:0];
                        3'd6: val = a | b;
                        default: val = a & b;
                    endcase
                end
                wr = !bad;
            end
            default: bad = 1'b1;
        endcase
        if (bad) begin
            npc = r_pc + 32'd4;
            wr  = 1'b0;
        end
    end

    assign ld_go  = r_mode && !halt && op == rvx_pkg::OP_LOAD && !bad;
    assign finish = r_busy && (r_phase || !ld_go) && slot_free;
    assign i_in.ready = !r_busy || finish;
    assign take = r_mode && !halt && wr && rd != 5'd0;

    assign rf_wr.we  = finish && take;
    assign rf_wr.idx = rd;
    assign rf_wr.val = val;

    // bank k holds bytes whose address is k modulo four
    always_comb begin
        logic [1:0]    off;
        logic [AW-1:0] ak;
        for (int k = 0; k < 4; k++) begin
            off     = 2'(2'(k) - maddr[1:0]);
            ak      = maddr + AW'(off);
            rrow[k] = ak[AW-1:2];
            wrow[k] = r_mode ? ak[AW-1:2] : laddr[AW-1:2];
            wdat[k] = r_mode ? b[8*off +: 8] : r_lb;
            if (!r_mode) begin
                we[k] = finish && laddr[1:0] == 2'(k);
            end else begin
                we[k] = finish && !halt && op == rvx_pkg::OP_STORE && !bad &&
                        (f3 == 3'd2 || (f3 == 3'd1 && off <= 2'd1) || off == 2'd0);
            end
        end
    end

    rvx_dmem #(.MEM_BYTES(MEM_BYTES)) u_dm (
        .i_clk(i_clk), .i_we(we), .i_wrow(wrow), .i_wdat(wdat),
        .i_re(r_busy && !r_phase && ld_go), .i_rrow(rrow), .o_rdat(q)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_in.mode;
            r_la   <= i_in.load_address;
            r_lb   <= i_in.load_byte;
            r_ins  <= i_in.instruction;
        end
        if (finish) begin
            r_o_npc  <= (!r_mode || halt) ? r_pc : npc;
            r_o_idx  <= take ? rd : 5'd0;
            r_o_val  <= take ? val : 32'd0;
            r_o_wr   <= take;
            r_o_halt <= r_mode && halt;
            r_o_bad  <= r_mode && !halt && bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_pc    <= 32'd0;
            r_out_v <= 1'b0;
        end else begin
            if (finish) begin
                r_phase <= 1'b0;
                if (r_mode && !halt) r_pc <= npc;
            end else if (r_busy && !r_phase && ld_go) begin
                r_phase <= 1'b1;
            end
            if (accept) r_busy <= 1'b1;
            else if (finish) r_busy <= 1'b0;
            if (finish) r_out_v <= 1'b1;
            else if (o_res.ready) r_out_v <= 1'b0;
        end
    end

    assign o_res.valid      = r_out_v;
    assign o_res.next_pc    = r_o_npc;
    assign o_res.dest_index = r_o_idx;
    assign o_res.dest_value = r_o_val;
    assign o_res.dest_write = r_o_wr;
    assign o_res.halted     = r_o_halt;
    assign o_res.illegal    = r_o_bad;

    a_no_x0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_wr.we |-> rf_wr.idx != 5'd0) else $error("write to x0");
    a_no_accept_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase && !finish) |-> !i_in.ready) else $error("accept during load wait");
    a_pc_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !finish |=> $stable(r_pc)) else $error("pc moved without a finished item");
    a_load_two_cycles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_phase && ld_go) |=> r_phase) else $error("load wait not entered");
endmodule

FILE: verif/tb.sv
// tb: self-checking bench for rv32i_instruction_execute over its item/result channels.
// Depends on rvx_pkg, rvx_if (rtl) and the DUT; predicts each result from its own RV32I model.
module tb;

    localparam int unsigned MEM = 65536;
    localparam int unsigned WDOG_LIMIT = 20000;

    typedef struct packed {
        logic        mode;
        logic [15:0] load_address;
        logic [7:0]  load_byte;
        logic [31:0] instruction;
    } t_item;

    typedef struct packed {
        logic [31:0] next_pc;
        logic [4:0]  dest_index;
        logic [31:0] dest_value;
        logic        dest_write;
        logic        halted;
        logic        illegal;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rvx_in_if  in_ch ();
    rvx_out_if res_ch ();

    rv32i_instruction_execute DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_res   (res_ch.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // architectural state of the predictor
    logic [31:0] arch_pc;
    logic [31:0] arch_regs [32];
    logic [7:0]  arch_mem [MEM];
    bit          mem_known [MEM];

    t_item pending_items [$];
    t_res  expected_results [$];
    int    mismatches = 0;
    bit    drain_hold = 1'b0;
    bit    stim_done = 1'b0;

    // stimulus-side shadow, tracks what has been written so loads only read known bytes
    logic [31:0] gen_regs [32];

    function automatic logic [31:0] sx(input logic [31:0] v, input int bits);
        logic [31:0] m;
        m = 32'hFFFF_FFFF << bits;
        return v[bits-1] ? (v | m) : (v & ~m);
    endfunction

    function automatic logic [7:0] mem_rd(input logic [31:0] a);
        return arch_mem[a[15:0]];
    endfunction

    function automatic t_res execute_item(input t_item it);
        t_res r;
        logic [31:0] ins, a, b, val, npc, addr, ii, is, ib, iu, ij;
        logic [6:0] op, f7;
        logic [4:0] rd, rs2;
        logic [2:0] f3;
        bit wr, bad, tk;
        r = '0;
        wr = 0; bad = 0; tk = 0; val = '0;
        if (!it.mode) begin
            arch_mem[it.load_address] = it.load_byte;
            r.next_pc = arch_pc;
            return r;
        end
        ins = it.instruction;
        if (ins == rvx_pkg::HALT_WORD) begin
            r.next_pc = arch_pc;
            r.halted = 1'b1;
            return r;
        end
        op = ins[6:0]; rd = ins[11:7]; f3 = ins[14:12]; rs2 = ins[24:20]; f7 = ins[31:25];
        a = arch_regs[ins[19:15]];
        b = arch_regs[rs2];
        ii = sx({20'b0, ins[31:20]}, 12);
        is = sx({20'b0, ins[31:25], ins[11:7]}, 12);
        ib = sx({19'b0, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0}, 13);
        iu = {ins[31:12], 12'b0};
        ij = sx({11'b0, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0}, 21);
        npc = arch_pc + 32'd4;
        case (op)
            rvx_pkg::OP_LUI: begin val = iu; wr = 1; end
            rvx_pkg::OP_AUIPC: begin val = arch_pc + iu; wr = 1; end
            rvx_pkg::OP_JAL: begin val = arch_pc + 4; npc = arch_pc + ij; wr = 1; end
            rvx_pkg::OP_JALR: begin
                if (f3 != 3'd0) bad = 1;
                else begin val = arch_pc + 4; npc = (a + ii) & ~32'd1; wr = 1; end
            end
            rvx_pkg::OP_BRANCH: begin
                case (f3)
                    3'd0: tk = (a == b);
                    3'd1: tk = (a != b);
                    3'd4: tk = $signed(a) < $signed(b);
                    3'd5: tk = !($signed(a) < $signed(b));
                    3'd6: tk = a < b;
                    3'd7: tk = a >= b;
                    default: bad = 1;
                endcase
                if (tk) npc = arch_pc + ib;
            end
            rvx_pkg::OP_LOAD: begin
                addr = a + ii;
                case (f3)
                    3'd0: val = sx({24'd0, mem_rd(addr)}, 8);
                    3'd1: val = sx({16'd0, mem_rd(addr + 1), mem_rd(addr)}, 16);
                    3'd2: val = {mem_rd(addr + 3), mem_rd(addr + 2), mem_rd(addr + 1),
                                 mem_rd(addr)};
                    3'd4: val = {24'd0, mem_rd(addr)};
                    3'd5: val = {16'd0, mem_rd(addr + 1), mem_rd(addr)};
                    default: bad = 1;
                endcase
                wr = !bad;
            end
            rvx_pkg::OP_STORE: begin
                addr = a + is;
                if (f3 > 3'd2) bad = 1;
                else begin
                    arch_mem[addr[15:0]] = b[7:0];
                    if (f3 >= 3'd1) arch_mem[16'(addr + 1)] = b[15:8];
                    if (f3 == 3'd2) begin
                        arch_mem[16'(addr + 2)] = b[23:16];
                        arch_mem[16'(addr + 3)] = b[31:24];
                    end
                end
            end
            rvx_pkg::OP_IMM: begin
                case (f3)
                    3'd0: val = a + ii;
                    3'd2: val = ($signed(a) < $signed(ii)) ? 1 : 0;
                    3'd3: val = (a < ii) ? 1 : 0;
                    3'd4: val = a ^ ii;
                    3'd6: val = a | ii;
                    3'd7: val = a & ii;
                    3'd1: if (f7 == rvx_pkg::F7_ZERO) val = a << rs2; else bad = 1;
                    default: begin
                        if (f7 == rvx_pkg::F7_ZERO) val = a >> rs2;
                        else if (f7 == rvx_pkg::F7_ALT) val = $signed(a) >>> rs2;
                        else bad = 1;
                    end
                endcase
                wr = !bad;
            end
            rvx_pkg::OP_REG: begin
                if (f7 == rvx_pkg::F7_ALT && f3 == 3'd0) val = a - b;
                else if (f7 == rvx_pkg::F7_ALT && f3 == 3'd5) val = $signed(a) >>> b[4:0];
                else if (f7 != rvx_pkg::F7_ZERO) bad = 1;
                else begin
                    case (f3)
                        3'd0: val = a + b;
                        3'd1: val = a << b[4:0];
                        3'd2: val = ($signed(a) < $signed(b)) ? 1 : 0;
                        3'd3: val = (a < b) ? 1 : 0;
                        3'd4: val = a ^ b;
                        3'd5: val = a >> b[4:0];
                        3'd6: val = a | b;
                        default: val = a & b;
                    endcase
                end
                wr = !bad;
            end
            default: bad = 1;
        endcase
        if (bad) begin
            npc = arch_pc + 4;
            wr = 0;
        end
        if (wr && rd != 5'd0) begin
            arch_regs[rd] = val;
            r.dest_index = rd;
            r.dest_value = val;
            r.dest_write = 1'b1;
        end
        arch_pc = npc;
        r.next_pc = npc;
        r.illegal = bad;
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic t_item ld_item(input logic [15:0] adr, input logic [7:0] by);
        t_item it;
        it.mode = 1'b0;
        it.load_address = adr;
        it.load_byte = by;
        it.instruction = 32'($urandom);
        return it;
    endfunction

    function automatic t_item ex_item(input logic [31:0] ins);
        t_item it;
        it.mode = 1'b1;
        it.load_address = 16'($urandom);
        it.load_byte = 8'($urandom);
        it.instruction = ins;
        return it;
    endfunction

    function automatic logic [31:0] enc_i(input logic [6:0] op, input logic [4:0] rd,
                                          input logic [2:0] f3, input logic [4:0] rs1,
                                          input logic [11:0] imm);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd, input logic [6:0] op);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_s(input logic [2:0] f3, input logic [4:0] rs1,
                                          input logic [4:0] rs2, input logic [11:0] imm);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], rvx_pkg::OP_STORE};
    endfunction

    // A load is only generated when every byte it touches was written. The generator
    // mirrors register values only for registers written by set_reg, so keep it simple:
    // loads use base x31, set by LUI/ADDI at the start of each phase, with a known absolute address.
    function automatic void push_exec(input logic [31:0] ins);
        pending_items.push_back(ex_item(ins));
    endfunction

    // set reg r to value v via LUI + ADDI
    function automatic void set_reg(input logic [4:0] r, input logic [31:0] v);
        logic [31:0] hi;
        hi = v + 32'h800;
        push_exec({hi[31:12], r, rvx_pkg::OP_LUI});
        push_exec(enc_i(rvx_pkg::OP_IMM, r, 3'd0, r, v[11:0]));
        gen_regs[r] = v;
    endfunction

    function automatic void fill_bytes(input logic [31:0] adr, input int n);
        for (int k = 0; k < n; k++) begin
            pending_items.push_back(ld_item(16'(adr + k), 8'($urandom)));
            mem_known[16'(adr + k)] = 1'b1;
        end
    endfunction

    function automatic bit known_span(input logic [31:0] adr, input int n);
        for (int k = 0; k < n; k++)
            if (!mem_known[16'(adr + k)]) return 0;
        return 1;
    endfunction

    // one random instruction; registers x1..x31 are random except x31 kept as memory base
    function automatic void rand_instr();
        logic [4:0] rd, rs1, rs2;
        logic [2:0] f3;
        logic [11:0] imm;
        logic [31:0] base, w;
        int sel, sz;
        rd = 5'($urandom_range(0, 30));
        rs1 = 5'($urandom);
        rs2 = 5'($urandom);
        f3 = 3'($urandom);
        imm = 12'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 25) begin
            push_exec(enc_r(($urandom_range(0, 1) ? rvx_pkg::F7_ALT : rvx_pkg::F7_ZERO),
                            rs2, rs1, f3, rd, rvx_pkg::OP_REG));
        end else if (sel < 45) begin
            if (f3 == 3'd1 || f3 == 3'd5)
                imm = {($urandom_range(0, 1) ? rvx_pkg::F7_ALT : rvx_pkg::F7_ZERO), imm[4:0]};
            push_exec(enc_i(rvx_pkg::OP_IMM, rd, f3, rs1, imm));
        end else if (sel < 55) begin
            push_exec({20'($urandom), rd,
                       ($urandom_range(0, 1) ? rvx_pkg::OP_LUI : rvx_pkg::OP_AUIPC)});
        end else if (sel < 63) begin
            push_exec({3'($urandom), 10'($urandom), 13'b0, ($urandom_range(0, 1) ? f3 : 3'd0),
                       rs2, rs1} == 0 ? 32'h13 : enc_r(7'($urandom), rs2, rs1,
                       3'($urandom_range(0, 7)), 5'($urandom), rvx_pkg::OP_BRANCH));
        end else if (sel < 68) begin
            push_exec({20'($urandom), rd, rvx_pkg::OP_JAL});
        end else if (sel < 72) begin
            push_exec(enc_i(rvx_pkg::OP_JALR, rd, ($urandom_range(0, 5) == 0) ? f3 : 3'd0,
                            rs1, imm));
        end else if (sel < 88) begin
            // memory access relative to x31 base: an optional store, then a load of known bytes
            base = gen_regs[31];
            sz = $urandom_range(0, 2);
            imm = 12'($urandom_range(0, 63));
            if ($urandom_range(0, 1)) begin
                push_exec(enc_s(3'(sz), 5'd31, rs2, imm));
                for (int k = 0; k < (1 << sz); k++) mem_known[16'(base + imm + k)] = 1'b1;
            end
            f3 = 3'($urandom_range(0, 7));
            sz = (f3[1:0] == 2'd0) ? 1 : (f3[1:0] == 2'd1) ? 2 : 4;
            if (f3 == 3'd3 || f3 >= 3'd6 || known_span(base + imm, sz))
                push_exec(enc_i(rvx_pkg::OP_LOAD, rd, f3, 5'd31, imm));
        end else if (sel < 93) begin
            fill_bytes(gen_regs[31] + $urandom_range(0, 63), 1);
        end else if (sel < 96) begin
            push_exec(enc_s(3'($urandom_range(3, 7)), rs1, rs2, imm));
        end else begin
            w = {25'($urandom), 7'($urandom)};
            // random loads would hit unwritten bytes; keep them as illegal-width loads
            if (w[6:0] == rvx_pkg::OP_LOAD) w[14:12] = 3'd3;
            push_exec(w);
        end
    endfunction

    // ---------------- driver ----------------
    int burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_items.size() != 0 && !drain_hold) begin
                t_item it;
                it = pending_items.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.mode <= it.mode;
                in_ch.load_address <= it.load_address;
                in_ch.load_byte <= it.load_byte;
                in_ch.instruction <= it.instruction;
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 20);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // prediction happens at acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            expected_results.push_back(execute_item({in_ch.mode, in_ch.load_address,
                                                     in_ch.load_byte, in_ch.instruction}));
    end

    // ---------------- monitor ----------------
    int stall_phase = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            stall_phase <= stall_phase + 1;
            // stall pattern: quiet windows alternate with busy ones
            res_ch.ready <= (stall_phase[8]) ? 1'b1 : ($urandom_range(0, 2) != 0);
            if (res_ch.valid && res_ch.ready) begin
                t_res got, exp_r;
                got = {res_ch.next_pc, res_ch.dest_index, res_ch.dest_value, res_ch.dest_write,
                       res_ch.halted, res_ch.illegal};
                if (expected_results.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected result %h", got);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("result mismatch: exp pc=%h rd=%0d val=%h we=%b h=%b il=%b",
                                     exp_r.next_pc, exp_r.dest_index, exp_r.dest_value,
                                     exp_r.dest_write, exp_r.halted, exp_r.illegal,
                                     "\n                 got pc=%h rd=%0d val=%h we=%b h=%b il=%b",
                                     got.next_pc, got.dest_index, got.dest_value,
                                     got.dest_write, got.halted, got.illegal);
                    end
                end
            end
        end
    end

    // ---------------- watchdog ----------------
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.mode = 1'b0;
        in_ch.load_address = '0;
        in_ch.load_byte = '0;
        in_ch.instruction = '0;
        res_ch.ready = 1'b0;
        arch_pc = '0;
        for (int k = 0; k < 32; k++) begin
            arch_regs[k] = '0;
            gen_regs[k] = '0;
        end
        for (int k = 0; k < MEM; k++) begin
            arch_mem[k] = '0;
            mem_known[k] = 1'b0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, memory wrap, every op class, halt, x0, illegal
        fill_bytes(32'hFFFE, 4);            // wraps past top of memory
        pending_items.push_back(ld_item(16'h0000, 8'hFF));
        mem_known[0] = 1'b1;
        set_reg(5'd31, 32'h0000_FFFE);
        push_exec(enc_i(rvx_pkg::OP_LOAD, 5'd1, 3'd2, 5'd31, 12'd0));   // word across the wrap
        push_exec(enc_i(rvx_pkg::OP_LOAD, 5'd2, 3'd0, 5'd31, 12'd2));
        push_exec(enc_i(rvx_pkg::OP_LOAD, 5'd3, 3'd5, 5'd31, 12'd1));
        push_exec(enc_r(rvx_pkg::F7_ALT, 5'd1, 5'd2, 3'd0, 5'd4, rvx_pkg::OP_REG));
        push_exec(enc_r(rvx_pkg::F7_ALT, 5'd3, 5'd1, 3'd5, 5'd5, rvx_pkg::OP_REG));
        push_exec(enc_i(rvx_pkg::OP_IMM, 5'd0, 3'd0, 5'd1, 12'hFFF));   // x0 destination
        push_exec(enc_i(rvx_pkg::OP_IMM, 5'd6, 3'd5, 5'd1, {rvx_pkg::F7_ALT, 5'd31}));
        push_exec(enc_i(rvx_pkg::OP_IMM, 5'd7, 3'd1, 5'd1, {rvx_pkg::F7_ALT, 5'd1})); // bad shift
        push_exec(enc_s(3'd2, 5'd31, 5'd4, 12'd8));
        push_exec(enc_r(7'h7F, 5'd1, 5'd2, 3'd2, 5'd9, rvx_pkg::OP_BRANCH)); // bad funct3
        push_exec(enc_r(7'h00, 5'd1, 5'd1, 3'd0, 5'd8, rvx_pkg::OP_BRANCH));
        push_exec(rvx_pkg::HALT_WORD);
        push_exec(32'hFFFF_FFFF);
        push_exec({20'hFFFFF, 5'd10, rvx_pkg::OP_JAL});
        push_exec(enc_i(rvx_pkg::OP_JALR, 5'd11, 3'd0, 5'd1, 12'h801));
        push_exec({20'hFFFFF, 5'd12, rvx_pkg::OP_AUIPC});
        push_exec(32'h0000_0000);
        pending_items.push_back(ld_item(16'hFFFF, 8'h00));
        pending_items.push_back(ld_item(16'h0000, 8'hFF));

        // pause until every expected result has arrived
        wait (pending_items.size() == 0);
        drain_hold = 1'b1;
        wait (expected_results.size() == 0 && !in_ch.valid);
        drain_hold = 1'b0;

        // random: program sequences around a fresh memory base each phase
        for (int ph = 0; ph < 3; ph++) begin
            set_reg(5'd31, {$urandom_range(0, 1) ? 16'hFFFF : 16'($urandom),
                            16'($urandom_range(0, 1) ? 16'hFFC0 : 16'($urandom))});
            fill_bytes(gen_regs[31], 64);
            for (int n = 0; n < 50; n++) rand_instr();
            wait (pending_items.size() == 0);
        end
        wait (expected_results.size() == 0 && !in_ch.valid);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
rtl/rvx_pkg.sv
rtl/rvx_if.sv
rtl/rvx_regfile.sv
rtl/rvx_dmem.sv
rtl/rv32i_instruction_execute.sv
verif/tb.sv
